// ----- design/lte_layer_demapper_core_macros.svh -----
// assertion macros for the layer demapper checker
// clocked on clk, disabled while arst_n is low
`ifndef LTE_LAYER_DEMAPPER_CORE_MACROS_SVH
`define LTE_LAYER_DEMAPPER_CORE_MACROS_SVH

// same-cycle implication or plain property
`define LLD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// next-cycle implication
`define LLD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`endif

// ----- design/lld_pkg.sv -----
// shared types and constants of the layer demapper
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lld_pkg;

	localparam int CFG_LEN_BITS = 12;
	localparam int CFG_DATA_BITS = CFG_LEN_BITS;

	// register indexes
	localparam logic CFG_VECTOR_LENGTH = 1'b0;
	localparam logic CFG_LAYER_MODE = 1'b1;

	typedef enum logic [1:0] {
		LAYERS_ONE = 2'd0,
		LAYERS_TWO = 2'd1,
		LAYERS_FOUR = 2'd2
	} layer_mode_t;

	typedef struct packed {
		logic [CFG_LEN_BITS-1:0] vector_length;
		layer_mode_t layer_mode;
	} cfg_t;

endpackage

`default_nettype wire

// ----- design/lld_store.sv -----
// two-bank sample store, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lld_store #(
	parameter int AW = 12,
	parameter int DW = 32
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data
);

	logic [DW-1:0] mem [0:(2**AW)-1];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- design/lld_addr_gen.sv -----
// write position clamp, last flag and interleaved read position
// depends on lld_pkg
`timescale 1ns / 1ps
`default_nettype none

module lld_addr_gen
	import lld_pkg::*;
#(
	parameter int MAX_VECTOR = 2048
) (
	input  wire cfg_t                          cfg,
	input  wire logic [$clog2(MAX_VECTOR)-1:0] write_pos,
	output logic      [$clog2(MAX_VECTOR)-1:0] pos,
	output logic      [$clog2(MAX_VECTOR)-1:0] src,
	output logic                               last
);

	localparam int PW = $clog2(MAX_VECTOR);
	localparam int LW = $clog2(MAX_VECTOR + 1);

	logic [LW-1:0] len;
	logic [LW-1:0] len_m1;
	logic [LW-1:0] q;
	logic [LW-1:0] span;
	logic [LW-1:0] off;
	logic [PW-1:0] div;

	always_comb begin
		if (cfg.vector_length == '0) begin
			len = LW'(1);
		end else if (32'(cfg.vector_length) > MAX_VECTOR) begin
			len = LW'(MAX_VECTOR);
		end else begin
			len = LW'(cfg.vector_length);
		end
		len_m1 = len - LW'(1);
		if (LW'(write_pos) >= len) begin
			pos = PW'(len_m1);
		end else begin
			pos = write_pos;
		end
		last = (LW'(pos) == len_m1);
	end

	always_comb begin
		case (cfg.layer_mode)
			LAYERS_TWO: begin
				q = len >> 1;
				span = len & ~LW'(1);
				off = pos[0] ? q : '0;
				div = pos >> 1;
			end
			LAYERS_FOUR: begin
				q = len >> 2;
				span = len & ~LW'(3);
				off = (pos[0] ? q : '0) + (pos[1] ? (q << 1) : '0);
				div = pos >> 2;
			end
			default: begin
				q = len;
				span = len;
				off = '0;
				div = pos;
			end
		endcase
		// trailing positions pass through in place
		if (LW'(pos) >= span || q == '0) begin
			src = pos;
		end else begin
			src = PW'(off + LW'(div));
		end
	end

endmodule

`default_nettype wire

// ----- design/lte_layer_demapper_core.sv -----
// layer demapper top level: config registers, bank control, output stage
// depends on lld_pkg, lld_addr_gen, lld_store
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------------
//  sample   | sample_valid / sample_ready | sample_re, sample_im
//  result   | result_valid / result_ready | out_re, out_im, vector_last
//  config   | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// one sample word per cycle sustained while the sample side does not stall, set by
// the single write port and the single read port of the two-bank store; a result passes
// through the store read register and the output register once the first full vector is in
// reset clears the position, bank and primed flags; the store is not cleared
// a stalled result holds in the output register while a new word is taken;
// the sample side stalls only when both output stages are full
// config writes are taken every cycle
`timescale 1ns / 1ps
`default_nettype none

module lte_layer_demapper_core
	import lld_pkg::*;
#(
	parameter int MAX_VECTOR = 2048,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          sample_valid,
	output logic                               sample_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_re,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_im,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic signed      [SAMPLE_BITS-1:0] out_re,
	output logic signed      [SAMPLE_BITS-1:0] out_im,
	output logic                               vector_last,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]      cfg_data
);

	localparam int PW = $clog2(MAX_VECTOR);
	localparam int AW = PW + 1;
	localparam int DW = 2 * SAMPLE_BITS;

	cfg_t cfg_q;
	logic [PW-1:0] write_pos_q;
	logic bank_q;
	logic primed_q;

	logic [PW-1:0] pos;
	logic [PW-1:0] src;
	logic last;
	logic accept;
	logic [DW-1:0] rd_data;

	logic valid_s1;
	logic last_s1;
	logic s2_load;

	logic result_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_re_q;
	logic signed [SAMPLE_BITS-1:0] out_im_q;
	logic vector_last_q;

	assign cfg_ready = 1'b1;
	assign s2_load = !result_valid_q || result_ready;
	assign sample_ready = !valid_s1 || s2_load;
	assign accept = sample_valid && sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vector_length <= CFG_LEN_BITS'(1);
			cfg_q.layer_mode <= LAYERS_ONE;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_VECTOR_LENGTH: cfg_q.vector_length <= cfg_data;
				CFG_LAYER_MODE: cfg_q.layer_mode <= layer_mode_t'(cfg_data[1:0]);
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	lld_addr_gen #(
		.MAX_VECTOR(MAX_VECTOR)
	) u_addr_gen (
		.cfg      (cfg_q),
		.write_pos(write_pos_q),
		.pos      (pos),
		.src      (src),
		.last     (last)
	);

	lld_store #(
		.AW(AW),
		.DW(DW)
	) u_store (
		.clk    (clk),
		.wr_en  (accept),
		.wr_addr({bank_q, pos}),
		.wr_data({sample_re, sample_im}),
		.rd_en  (accept && primed_q),
		.rd_addr({~bank_q, src}),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos_q <= '0;
			bank_q <= 1'b0;
			primed_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				write_pos_q <= '0;
				bank_q <= ~bank_q;
				primed_q <= 1'b1;
			end else begin
				write_pos_q <= pos + PW'(1);
			end
		end
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= primed_q;
		end else if (s2_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= last;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s2_load) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load && valid_s1) begin
			out_re_q <= rd_data[DW-1:SAMPLE_BITS];
			out_im_q <= rd_data[SAMPLE_BITS-1:0];
			vector_last_q <= last_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign out_re = out_re_q;
	assign out_im = out_im_q;
	assign vector_last = vector_last_q;

endmodule

`default_nettype wire

// ----- design/lld_checker.sv -----
// port-level checks of the layer demapper, bound to the top level
// depends on lte_layer_demapper_core_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "lte_layer_demapper_core_macros.svh"

module lld_checker #(
	parameter int SAMPLE_BITS = 16
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          sample_valid,
	input wire logic                          sample_ready,
	input wire logic                          result_valid,
	input wire logic                          result_ready,
	input wire logic signed [SAMPLE_BITS-1:0] out_re,
	input wire logic signed [SAMPLE_BITS-1:0] out_im,
	input wire logic                          vector_last
);

	// a stalled result word holds
	`LLD_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(out_re) && $stable(out_im) && $stable(vector_last), "result word changed while stalled")

	// with the output register empty the sample side never stalls
	`LLD_ASSERT(a_ready_when_empty, !result_valid |-> sample_ready, "sample stalled with empty output")

	// a new result follows an accepted sample word
	`LLD_ASSERT(a_result_source, $rose(result_valid) |-> $past(sample_valid && sample_ready, 2), "result without accepted sample word")

endmodule

bind lte_layer_demapper_core lld_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_lld_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.sample_valid(sample_valid),
	.sample_ready(sample_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.out_re      (out_re),
	.out_im      (out_im),
	.vector_last (vector_last)
);

`default_nettype wire

// ----- tb/sv/lte_layer_demapper_core_checker.sv -----
// checker for the layer demapper: tracks config writes, predicts the reordered words
// and compares them with the result channel; depends on lld_pkg
`timescale 1ns / 1ps

module lte_layer_demapper_core_checker
	import lld_pkg::*;
#(
	parameter int MAX_VECTOR = 2048,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	input  logic                          sample_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_re,
	input  logic signed [SAMPLE_BITS-1:0] sample_im,
	input  logic                          result_valid,
	input  logic                          result_ready,
	input  logic signed [SAMPLE_BITS-1:0] out_re,
	input  logic signed [SAMPLE_BITS-1:0] out_im,
	input  logic                          vector_last,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [CFG_DATA_BITS-1:0]      cfg_data,
	output int                            mismatches,
	output int                            words_owed
);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] re;
		logic signed [SAMPLE_BITS-1:0] im;
		logic                          last;
	} demapped_t;

	demapped_t owed_words[$];

	logic signed [SAMPLE_BITS-1:0] bank_re [2*MAX_VECTOR];
	logic signed [SAMPLE_BITS-1:0] bank_im [2*MAX_VECTOR];

	logic [CFG_LEN_BITS-1:0] len_reg;
	logic [1:0]              mode_reg;
	int                      wr_pos;
	logic                    bank_sel;
	logic                    primed;

	function automatic int interleave_src(input int j, input int len, input logic [1:0] mode);
		int n;
		int q;
		n = (mode == LAYERS_TWO) ? 2 : (mode == LAYERS_FOUR) ? 4 : 1;
		q = len / n;
		if (j >= q * n)
			return j;
		return (j % n) * q + j / n;
	endfunction

	task automatic predict_word(input logic signed [SAMPLE_BITS-1:0] re,
			input logic signed [SAMPLE_BITS-1:0] im);
		int        len;
		int        pos;
		int        cur;
		int        prv;
		int        src;
		logic      last;
		demapped_t word;
		if (len_reg == '0)
			len = 1;
		else if (int'(len_reg) > MAX_VECTOR)
			len = MAX_VECTOR;
		else
			len = int'(len_reg);
		pos = (wr_pos >= len) ? len - 1 : wr_pos;
		cur = bank_sel ? MAX_VECTOR : 0;
		prv = bank_sel ? 0 : MAX_VECTOR;
		last = (pos == len - 1);
		bank_re[cur + pos] = re;
		bank_im[cur + pos] = im;
		if (primed) begin
			src = interleave_src(pos, len, mode_reg);
			word.re = bank_re[prv + src];
			word.im = bank_im[prv + src];
			word.last = last;
			owed_words.push_back(word);
		end
		if (last) begin
			wr_pos = 0;
			bank_sel = !bank_sel;
			primed = 1'b1;
		end else begin
			wr_pos = pos + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		demapped_t due;
		if (!arst_n) begin
			len_reg = CFG_LEN_BITS'(1);
			mode_reg = LAYERS_ONE;
			wr_pos = 0;
			bank_sel = 1'b0;
			primed = 1'b0;
			owed_words.delete();
			mismatches = 0;
			words_owed = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_VECTOR_LENGTH)
					len_reg = cfg_data[CFG_LEN_BITS-1:0];
				else
					mode_reg = cfg_data[1:0];
			end
			if (sample_valid && sample_ready)
				predict_word(sample_re, sample_im);
			if (result_valid && result_ready) begin
				if (owed_words.size() == 0) begin
					$error("result word with none expected: out_re %0d, out_im %0d, vector_last %0b",
						out_re, out_im, vector_last);
					mismatches++;
				end else begin
					due = owed_words.pop_front();
					if (out_re !== due.re) begin
						$error("out_re: expected %0d, got %0d", due.re, out_re);
						mismatches++;
					end
					if (out_im !== due.im) begin
						$error("out_im: expected %0d, got %0d", due.im, out_im);
						mismatches++;
					end
					if (vector_last !== due.last) begin
						$error("vector_last: expected %0b, got %0b", due.last, vector_last);
						mismatches++;
					end
				end
			end
			words_owed = owed_words.size();
		end
	end

endmodule

// ----- tb/sv/lte_layer_demapper_core_tb.sv -----
// testbench top for the layer demapper: clock, reset, sample and config stimulus,
// result-side stalls and the verdict; depends on lld_pkg and the checker module
`timescale 1ns / 1ps

module lte_layer_demapper_core_tb;
	import lld_pkg::*;

	localparam int MAX_VECTOR = 2048;
	localparam int SAMPLE_BITS = 16;
	localparam int CLK_PERIOD = 8;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int FILL_LEN = 256;
	localparam int RANDOM_WORDS = 1130;
	localparam logic [1:0] LAYERS_RESERVED = 2'd3;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          sample_valid;
	logic                          sample_ready;
	logic signed [SAMPLE_BITS-1:0] sample_re;
	logic signed [SAMPLE_BITS-1:0] sample_im;
	logic                          result_valid;
	logic                          result_ready;
	logic signed [SAMPLE_BITS-1:0] out_re;
	logic signed [SAMPLE_BITS-1:0] out_im;
	logic                          vector_last;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic                          cfg_index;
	logic [CFG_DATA_BITS-1:0]      cfg_data;
	int                            mismatches;
	int                            words_owed;

	bit calm = 1'b0;
	bit squeeze = 1'b0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	lte_layer_demapper_core #(
		.MAX_VECTOR(MAX_VECTOR),
		.SAMPLE_BITS(SAMPLE_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample_re(sample_re),
		.sample_im(sample_im),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.out_re(out_re),
		.out_im(out_im),
		.vector_last(vector_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	lte_layer_demapper_core_checker #(
		.MAX_VECTOR(MAX_VECTOR),
		.SAMPLE_BITS(SAMPLE_BITS)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample_re(sample_re),
		.sample_im(sample_im),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.out_re(out_re),
		.out_im(out_im),
		.vector_last(vector_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.words_owed(words_owed)
	);

	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] re,
			input logic signed [SAMPLE_BITS-1:0] im);
		if (!calm && $urandom_range(99) < 8) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_re <= re;
		sample_im <= im;
		do @(posedge clk); while (!sample_ready);
	endtask

	task automatic send_random(input int count);
		repeat (count) send_sample(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_DATA_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_layout(input logic [CFG_DATA_BITS-1:0] vec_len, input logic [1:0] mode,
			input bit length_only);
		if (length_only) begin
			write_reg(CFG_VECTOR_LENGTH, vec_len);
		end else if ($urandom_range(1)) begin
			write_reg(CFG_VECTOR_LENGTH, vec_len);
			write_reg(CFG_LAYER_MODE, CFG_DATA_BITS'(mode));
		end else begin
			write_reg(CFG_LAYER_MODE, CFG_DATA_BITS'(mode));
			write_reg(CFG_VECTOR_LENGTH, vec_len);
		end
		cfg_valid <= 1'b0;
	endtask

	// drain the result side, then give the pipeline time to go quiet
	task automatic settle();
		sample_valid <= 1'b0;
		do @(negedge clk); while (words_owed != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [CFG_DATA_BITS-1:0] vec_len, input logic [1:0] mode,
			input bit length_only, input int count);
		set_layout(vec_len, mode, length_only);
		send_random(count);
		settle();
	endtask

	initial begin : result_sink
		bit held_off;
		held_off = 1'b0;
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze && !held_off) begin
				held_off = 1'b1;
				result_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				result_ready <= calm || ($urandom_range(99) >= 8);
			end
		end
	end

	initial begin : stimulus
		int                       phase;
		int                       random_words;
		int                       eff_len;
		int                       count;
		logic [CFG_DATA_BITS-1:0] vec_len;
		logic [1:0]               mode;
		arst_n <= 1'b0;
		sample_valid <= 1'b0;
		sample_re <= '0;
		sample_im <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_VECTOR_LENGTH;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// two vectors fill the low part of both banks, later reads stay inside it
		run_phase(CFG_DATA_BITS'(FILL_LEN), LAYERS_RESERVED, 1'b0, FILL_LEN);
		run_phase(CFG_DATA_BITS'(FILL_LEN), LAYERS_FOUR, 1'b0, FILL_LEN);

		// full-size and oversized lengths, single layer, short partial vector
		run_phase(CFG_DATA_BITS'(MAX_VECTOR), LAYERS_ONE, 1'b0, 16);
		run_phase('1, LAYERS_ONE, 1'b1, 16);

		// one-word vectors carry the sample extremes straight through
		set_layout(CFG_DATA_BITS'(1), LAYERS_ONE, 1'b0);
		send_sample({1'b0, {(SAMPLE_BITS-1){1'b1}}}, {1'b1, {(SAMPLE_BITS-1){1'b0}}});
		send_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}}, {1'b0, {(SAMPLE_BITS-1){1'b1}}});
		send_sample('0, '1);
		send_random(1);
		settle();
		run_phase('0, LAYERS_FOUR, 1'b0, 2);
		run_phase(CFG_DATA_BITS'(5), LAYERS_TWO, 1'b0, 5);
		run_phase(CFG_DATA_BITS'(6), LAYERS_FOUR, 1'b0, 6);
		run_phase(CFG_DATA_BITS'(3), LAYERS_RESERVED, 1'b0, 3);
		// length cut below the write position in mid vector
		run_phase(CFG_DATA_BITS'(9), LAYERS_ONE, 1'b0, 5);
		run_phase(CFG_DATA_BITS'(4), LAYERS_ONE, 1'b1, 2);

		phase = 0;
		random_words = 0;
		while (random_words < RANDOM_WORDS) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: vec_len = CFG_DATA_BITS'($urandom_range(1, 16));
				6, 7: vec_len = CFG_DATA_BITS'($urandom_range(17, 64));
				8: vec_len = CFG_DATA_BITS'($urandom_range(0, 8));
				default: vec_len = CFG_DATA_BITS'($urandom_range(65, FILL_LEN));
			endcase
			mode = 2'($urandom_range(3));
			if (vec_len == '0)
				eff_len = 1;
			else if (int'(vec_len) > MAX_VECTOR)
				eff_len = MAX_VECTOR;
			else
				eff_len = int'(vec_len);
			count = $urandom_range(1, (eff_len < 28) ? 2 * eff_len + 3 : 60);
			calm = (phase >= 8 && phase < 12);
			if (phase == 4) begin
				squeeze = 1'b1;
				count = 80;
			end
			run_phase(vec_len, mode, $urandom_range(3) == 0, count);
			squeeze = 1'b0;
			random_words += count;
			phase++;
		end
		calm = 1'b0;

		settle();
		if (mismatches == 0 && words_owed == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin : watchdog
		#4_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
